@@ rtl/swk_pkg.sv @@
// ----------------------------------------------------------------------------
// swk_pkg
// Shared constants, types and the CORDIC arctangent table for the swerve
// wheel kinematics pipeline.
// ----------------------------------------------------------------------------
package swk_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int STAGES = (CORDIC_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STAGES;

   localparam int W_CMD  = 16;
   localparam int W_DATA = 36;
   localparam int W_ANG  = 34;
   localparam int W_MAG  = 32;
   localparam int W_PROD = W_DATA + 31;
   localparam int W_QUO  = 16;
   localparam int W_NUM  = W_MAG + W_QUO - 1;

   localparam int INV_GAIN  = 652032874;
   localparam int POLAR_LAT = STAGES + 3;
   localparam int DIV_LAT   = W_QUO;

   typedef logic signed [W_DATA-1:0] data_type;
   typedef logic signed [W_ANG-1:0]  ang_type;
   typedef logic signed [W_PROD-1:0] prod_type;

   localparam ang_type  HALF_TURN = {2'b00, 1'b1, 31'd0};
   localparam prod_type INV_GAIN_P = prod_type'(INV_GAIN);
   localparam prod_type ROUND_30 = prod_type'(1) <<< 29;

   typedef enum logic {
      REG_LENGTH = 1'b0,
      REG_WIDTH  = 1'b1
   } csr_index_type;

   function automatic ang_type atan_turns(input logic [4:0] idx);
      ang_type r;
      unique case (idx)
         5'd0:  r = 34'sd536870912;
         5'd1:  r = 34'sd316933406;
         5'd2:  r = 34'sd167458907;
         5'd3:  r = 34'sd85004756;
         5'd4:  r = 34'sd42667331;
         5'd5:  r = 34'sd21354465;
         5'd6:  r = 34'sd10679838;
         5'd7:  r = 34'sd5340245;
         5'd8:  r = 34'sd2670163;
         5'd9:  r = 34'sd1335087;
         5'd10: r = 34'sd667544;
         5'd11: r = 34'sd333772;
         5'd12: r = 34'sd166886;
         5'd13: r = 34'sd83443;
         5'd14: r = 34'sd41722;
         5'd15: r = 34'sd20861;
         5'd16: r = 34'sd10430;
         5'd17: r = 34'sd5215;
         5'd18: r = 34'sd2608;
         5'd19: r = 34'sd1304;
         5'd20: r = 34'sd652;
         5'd21: r = 34'sd326;
         5'd22: r = 34'sd163;
         5'd23: r = 34'sd81;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/swk_polar.sv @@
// ----------------------------------------------------------------------------
// swk_polar
// Pipelined vectoring CORDIC: magnitude and atan2(p, q) of one wheel pair.
// ----------------------------------------------------------------------------
module swk_polar import swk_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  data_type          p,
   input  data_type          q,
   output logic [W_MAG-1:0]  mag,
   output logic [15:0]       ang
);

   data_type x_ff [0:STAGES];
   data_type y_ff [0:STAGES];
   ang_type  z_ff [0:STAGES];
   logic     zero_ff [0:STAGES];

   prod_type    prod_ff;
   logic [15:0] ang_ff;
   logic        zero2_ff;

   ang_type  z_rnd;
   prod_type m_rnd;

   always_ff @(posedge clock) begin
      if (en) begin
         zero_ff[0] <= (p == '0) && (q == '0);
         if (q[W_DATA-1]) begin
            x_ff[0] <= -q;
            y_ff[0] <= -p;
            z_ff[0] <= HALF_TURN;
         end else begin
            x_ff[0] <= q;
            y_ff[0] <= p;
            z_ff[0] <= '0;
         end
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (en) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][W_DATA-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_turns(5'(i));
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_turns(5'(i));
            end
         end
      end
   end

   assign z_rnd = z_ff[STAGES] + ang_type'(32768);
   assign m_rnd = (prod_ff + ROUND_30) >>> 30;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff  <= prod_type'(x_ff[STAGES]) * INV_GAIN_P;
         ang_ff   <= z_rnd[31:16];
         zero2_ff <= zero_ff[STAGES];
         mag      <= (zero2_ff || m_rnd[W_PROD-1]) ? '0 : W_MAG'(m_rnd);
         ang      <= zero2_ff ? '0 : ang_ff;
      end
   end

endmodule

@@ rtl/swk_divider.sv @@
// ----------------------------------------------------------------------------
// swk_divider
// Pipelined restoring divider: round(mag * 32768 / mx), one quotient bit
// per stage.
// ----------------------------------------------------------------------------
module swk_divider import swk_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [W_MAG-1:0]  mag,
   input  logic [W_MAG-1:0]  mx,
   output logic [W_QUO-1:0]  quo
);

   logic [W_NUM-1:0] r_ff [1:W_QUO];
   logic [W_MAG-1:0] d_ff [1:W_QUO];
   logic [W_QUO-1:0] q_ff [1:W_QUO];

   logic [W_NUM-1:0] r_cur [0:W_QUO-1];
   logic [W_MAG-1:0] d_cur [0:W_QUO-1];
   logic [W_QUO-1:0] q_cur [0:W_QUO-1];

   assign r_cur[0] = {mag, {(W_QUO-1){1'b0}}} + W_NUM'(mx >> 1);
   assign d_cur[0] = mx;
   assign q_cur[0] = '0;

   for (genvar j = 1; j < W_QUO; j++) begin : g_link
      assign r_cur[j] = r_ff[j];
      assign d_cur[j] = d_ff[j];
      assign q_cur[j] = q_ff[j];
   end

   for (genvar j = 0; j < W_QUO; j++) begin : g_step
      localparam int B = W_QUO - 1 - j;
      logic [W_NUM-1:0] sub;
      assign sub = W_NUM'(d_cur[j]) << B;
      always_ff @(posedge clock) begin
         if (en) begin
            d_ff[j+1] <= d_cur[j];
            if (r_cur[j] >= sub) begin
               r_ff[j+1] <= r_cur[j] - sub;
               q_ff[j+1] <= q_cur[j] | (W_QUO'(1) << B);
            end else begin
               r_ff[j+1] <= r_cur[j];
               q_ff[j+1] <= q_cur[j];
            end
         end
      end
   end

   assign quo = q_ff[W_QUO];

endmodule

@@ rtl/swerve_wheel_kinematics.sv @@
// ----------------------------------------------------------------------------
// swerve_wheel_kinematics
// Four-wheel swerve inverse kinematics: optional field rotation, wheel
// pairs, CORDIC magnitude/angle per wheel and speed normalization.
//
//   channel  ports   handshake          beat
//   req      req_*   valid / stall      one drive command
//   rsp      rsp_*   valid / stall      four speeds, four angles
//   csr      csr_*   write enable       one register write
//
// One beat enters per cycle while req_stall is low. The pipeline depth
// is set by the field-rotation and vectoring CORDIC chains and the
// 16-stage divider. Reset clears all valid bits and restores the
// ratios. A stalled result parks in a skid register; req_stall rises only
// while that register is full.
// ----------------------------------------------------------------------------
module swerve_wheel_kinematics import swk_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [15:0]  req_strafe_cmd,
   input  logic signed [15:0]  req_forward_cmd,
   input  logic signed [15:0]  req_rotate_cmd,
   input  logic [15:0]         req_heading,
   input  logic                req_field_oriented,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [15:0]         rsp_front_left_speed,
   output logic [15:0]         rsp_front_right_speed,
   output logic [15:0]         rsp_back_left_speed,
   output logic [15:0]         rsp_back_right_speed,
   output logic [15:0]         rsp_front_left_angle,
   output logic [15:0]         rsp_front_right_angle,
   output logic [15:0]         rsp_back_left_angle,
   output logic [15:0]         rsp_back_right_angle,
   input  logic                csr_write,
   input  logic [0:0]          csr_index,
   input  logic [15:0]         csr_data
);

   typedef struct packed {
      logic [3:0][15:0] speed;
      logic [3:0][15:0] ang;
   } rsp_type;

   typedef struct packed {
      logic             big;
      logic [3:0][15:0] small_spd;
      logic [3:0][15:0] ang;
   } carry_type;

   logic en;
   logic [15:0] length_ratio_ff, width_ratio_ff;

   // config
   always_ff @(posedge clock) begin
      if (reset) begin
         length_ratio_ff <= 16'd46341;
         width_ratio_ff  <= 16'd46341;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            REG_LENGTH: length_ratio_ff <= csr_data;
            REG_WIDTH:  width_ratio_ff  <= csr_data;
         endcase
      end
   end

   // input stage
   logic                    s0_v_ff, s0_fo_ff;
   logic signed [W_CMD-1:0] s0_x_ff, s0_y_ff, s0_z_ff;
   logic [15:0]             s0_head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_x_ff    <= req_strafe_cmd;
         s0_y_ff    <= req_forward_cmd;
         s0_z_ff    <= req_rotate_cmd;
         s0_head_ff <= req_heading;
         s0_fo_ff   <= req_field_oriented;
      end
   end

   // quarter turn, residual angle, z*ratio
   logic [15:0]        hsum;
   logic signed [14:0] res14;
   data_type           x_full, y_full, qx, qy;
   logic signed [32:0] zlp, zwp;

   assign hsum   = s0_head_ff + 16'd8192;
   assign res14  = $signed({1'b0, hsum[13:0]}) - 15'sd8192;
   assign x_full = data_type'(s0_x_ff) <<< 14;
   assign y_full = data_type'(s0_y_ff) <<< 14;
   assign zlp    = $signed(s0_z_ff) * $signed({1'b0, length_ratio_ff});
   assign zwp    = $signed(s0_z_ff) * $signed({1'b0, width_ratio_ff});

   always_comb begin
      unique case (hsum[15:14])
         2'd0: begin qx = x_full;  qy = y_full;  end
         2'd1: begin qx = -y_full; qy = x_full;  end
         2'd2: begin qx = -x_full; qy = -y_full; end
         2'd3: begin qx = y_full;  qy = -x_full; end
      endcase
   end

   // field rotation CORDIC
   logic                    rot_v_ff  [0:STAGES];
   logic                    rot_fo_ff [0:STAGES];
   data_type                rot_x_ff  [0:STAGES];
   data_type                rot_y_ff  [0:STAGES];
   ang_type                 rot_z_ff  [0:STAGES];
   logic signed [W_CMD-1:0] rot_xr_ff [0:STAGES];
   logic signed [W_CMD-1:0] rot_yr_ff [0:STAGES];
   data_type                rot_zl_ff [0:STAGES];
   data_type                rot_zw_ff [0:STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_v_ff[0] <= 1'b0;
      end else if (en) begin
         rot_v_ff[0] <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rot_fo_ff[0] <= s0_fo_ff;
         rot_x_ff[0]  <= qx;
         rot_y_ff[0]  <= qy;
         rot_z_ff[0]  <= ang_type'(res14) <<< 16;
         rot_xr_ff[0] <= s0_x_ff;
         rot_yr_ff[0] <= s0_y_ff;
         rot_zl_ff[0] <= data_type'((zlp + 33'sd2) >>> 2);
         rot_zw_ff[0] <= data_type'((zwp + 33'sd2) >>> 2);
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_rot
      always_ff @(posedge clock) begin
         if (reset) begin
            rot_v_ff[i+1] <= 1'b0;
         end else if (en) begin
            rot_v_ff[i+1] <= rot_v_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rot_fo_ff[i+1] <= rot_fo_ff[i];
            rot_xr_ff[i+1] <= rot_xr_ff[i];
            rot_yr_ff[i+1] <= rot_yr_ff[i];
            rot_zl_ff[i+1] <= rot_zl_ff[i];
            rot_zw_ff[i+1] <= rot_zw_ff[i];
            if (!rot_z_ff[i][W_ANG-1]) begin
               rot_x_ff[i+1] <= rot_x_ff[i] - (rot_y_ff[i] >>> i);
               rot_y_ff[i+1] <= rot_y_ff[i] + (rot_x_ff[i] >>> i);
               rot_z_ff[i+1] <= rot_z_ff[i] - atan_turns(5'(i));
            end else begin
               rot_x_ff[i+1] <= rot_x_ff[i] + (rot_y_ff[i] >>> i);
               rot_y_ff[i+1] <= rot_y_ff[i] - (rot_x_ff[i] >>> i);
               rot_z_ff[i+1] <= rot_z_ff[i] + atan_turns(5'(i));
            end
         end
      end
   end

   // gain removal product
   logic                    g_v_ff, g_fo_ff;
   prod_type                g_px_ff, g_py_ff;
   logic signed [W_CMD-1:0] g_xr_ff, g_yr_ff;
   data_type                g_zl_ff, g_zw_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_v_ff <= 1'b0;
      end else if (en) begin
         g_v_ff <= rot_v_ff[STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         g_fo_ff <= rot_fo_ff[STAGES];
         g_px_ff <= prod_type'(rot_x_ff[STAGES]) * INV_GAIN_P;
         g_py_ff <= prod_type'(rot_y_ff[STAGES]) * INV_GAIN_P;
         g_xr_ff <= rot_xr_ff[STAGES];
         g_yr_ff <= rot_yr_ff[STAGES];
         g_zl_ff <= rot_zl_ff[STAGES];
         g_zw_ff <= rot_zw_ff[STAGES];
      end
   end

   // wheel pairs
   prod_type px_rnd, py_rnd;
   data_type fx, fy;
   logic     k_v_ff;
   data_type k_a_ff, k_b_ff, k_c_ff, k_d_ff;

   assign px_rnd = (g_px_ff + ROUND_30) >>> 30;
   assign py_rnd = (g_py_ff + ROUND_30) >>> 30;
   assign fx = g_fo_ff ? data_type'(px_rnd) : (data_type'(g_xr_ff) <<< 14);
   assign fy = g_fo_ff ? data_type'(py_rnd) : (data_type'(g_yr_ff) <<< 14);

   always_ff @(posedge clock) begin
      if (reset) begin
         k_v_ff <= 1'b0;
      end else if (en) begin
         k_v_ff <= g_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         k_a_ff <= fx - g_zl_ff;
         k_b_ff <= fx + g_zl_ff;
         k_c_ff <= fy - g_zw_ff;
         k_d_ff <= fy + g_zw_ff;
      end
   end

   // per-wheel CORDIC: FL(b,c) FR(b,d) BL(a,c) BR(a,d)
   logic [W_MAG-1:0] mag [0:3];
   logic [15:0]      ang [0:3];
   data_type         pp  [0:3];
   data_type         pq  [0:3];

   assign pp[0] = k_b_ff;  assign pq[0] = k_c_ff;
   assign pp[1] = k_b_ff;  assign pq[1] = k_d_ff;
   assign pp[2] = k_a_ff;  assign pq[2] = k_c_ff;
   assign pp[3] = k_a_ff;  assign pq[3] = k_d_ff;

   for (genvar w = 0; w < 4; w++) begin : g_polar
      swk_polar u_polar (
         .clock (clock),
         .en    (en),
         .p     (pp[w]),
         .q     (pq[w]),
         .mag   (mag[w]),
         .ang   (ang[w])
      );
   end

   logic pv_ff [1:POLAR_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= POLAR_LAT; i++) pv_ff[i] <= 1'b0;
      end else if (en) begin
         pv_ff[1] <= k_v_ff;
         for (int i = 2; i <= POLAR_LAT; i++) pv_ff[i] <= pv_ff[i-1];
      end
   end

   // largest speed
   logic             m1_v_ff, m2_v_ff;
   logic [W_MAG-1:0] m1_m01_ff, m1_m23_ff, m2_mx_ff;
   logic [W_MAG-1:0] m1_mag_ff [0:3];
   logic [W_MAG-1:0] m2_mag_ff [0:3];
   logic [3:0][15:0] m1_ang_ff;
   carry_type        m2_carry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_v_ff <= 1'b0;
         m2_v_ff <= 1'b0;
      end else if (en) begin
         m1_v_ff <= pv_ff[POLAR_LAT];
         m2_v_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_m01_ff <= (mag[1] > mag[0]) ? mag[1] : mag[0];
         m1_m23_ff <= (mag[3] > mag[2]) ? mag[3] : mag[2];
         m2_mx_ff  <= (m1_m23_ff > m1_m01_ff) ? m1_m23_ff : m1_m01_ff;
         m2_carry_ff.big <= ((m1_m23_ff > m1_m01_ff) ? m1_m23_ff : m1_m01_ff)
                            > (W_MAG'(1) << 29);
         for (int w = 0; w < 4; w++) begin
            m1_mag_ff[w] <= mag[w];
            m1_ang_ff[w] <= ang[w];
            m2_mag_ff[w] <= m1_mag_ff[w];
            m2_carry_ff.small_spd[w] <= 16'((m1_mag_ff[w] + W_MAG'(8192)) >> 14);
            m2_carry_ff.ang[w] <= m1_ang_ff[w];
         end
      end
   end

   // normalization
   logic [W_QUO-1:0] quo [0:3];

   for (genvar w = 0; w < 4; w++) begin : g_div
      swk_divider u_div (
         .clock (clock),
         .en    (en),
         .mag   (m2_mag_ff[w]),
         .mx    (m2_mx_ff),
         .quo   (quo[w])
      );
   end

   logic      dv_ff    [1:DIV_LAT];
   carry_type dcarry_ff [1:DIV_LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= DIV_LAT; i++) dv_ff[i] <= 1'b0;
      end else if (en) begin
         dv_ff[1] <= m2_v_ff;
         for (int i = 2; i <= DIV_LAT; i++) dv_ff[i] <= dv_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dcarry_ff[1] <= m2_carry_ff;
         for (int i = 2; i <= DIV_LAT; i++) dcarry_ff[i] <= dcarry_ff[i-1];
      end
   end

   logic    last_valid;
   rsp_type last_rsp;

   assign last_valid = dv_ff[DIV_LAT];

   always_comb begin
      for (int w = 0; w < 4; w++) begin
         last_rsp.speed[w] = dcarry_ff[DIV_LAT].big ? quo[w]
                                                    : dcarry_ff[DIV_LAT].small_spd[w];
         last_rsp.ang[w]   = dcarry_ff[DIV_LAT].ang[w];
      end
   end

   // output register and skid
   logic    rsp_valid_ff, skid_valid_ff;
   rsp_type rsp_ff, skid_ff;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= last_valid;
         end
      end else if (last_valid && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || !rsp_stall) begin
         rsp_ff <= skid_valid_ff ? skid_ff : last_rsp;
      end else if (last_valid && en) begin
         skid_ff <= last_rsp;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_front_left_speed  = rsp_ff.speed[0];
   assign rsp_front_right_speed = rsp_ff.speed[1];
   assign rsp_back_left_speed   = rsp_ff.speed[2];
   assign rsp_back_right_speed  = rsp_ff.speed[3];
   assign rsp_front_left_angle  = rsp_ff.ang[0];
   assign rsp_front_right_angle = rsp_ff.ang[1];
   assign rsp_back_left_angle   = rsp_ff.ang[2];
   assign rsp_back_right_angle  = rsp_ff.ang[3];

endmodule
